>>> design/sha0_pkg.sv
package sha0_pkg;

	typedef logic [31:0] word_t;
	typedef logic [7:0]  byte_t;

	localparam int WORD_COUNT  = 5;
	localparam int BLOCK_BYTES = 64;
	localparam int LEN_POS     = 56;
	localparam int PHASE_LEN   = 20;

	localparam byte_t PAD_BYTE = 8'h80;

	typedef word_t [WORD_COUNT-1:0] chain_t;

	// round constants, one per group of twenty rounds
	localparam word_t [3:0] ROUND_K = '{
		32'hCA62C1D6, 32'h8F1BBCDC, 32'h6ED9EBA1, 32'h5A827999
	};

	// initial chaining value
	localparam chain_t INIT_H = '{
		32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
	};

	// round function select
	typedef enum logic [1:0] {
		PH_CHOOSE  = 2'd0,
		PH_PARITY1 = 2'd1,
		PH_MAJOR   = 2'd2,
		PH_PARITY2 = 2'd3
	} phase_t;

	// sequencer states
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_PAD   = 5'b00010,
		ST_ROUND = 5'b00100,
		ST_FOLD  = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	// control from the sequencer to the round unit
	typedef struct packed {
		logic   load;
		logic   step;
		phase_t phase;
	} round_ctrl_t;

endpackage

>>> design/sha0_in_if.sv
interface sha0_in_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [7:0] data_byte;

	modport source (output valid, output operation, output data_byte, input ready);
	modport sink (input valid, input operation, input data_byte, output ready);
endinterface

>>> design/sha0_out_if.sv
interface sha0_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	logic        too_long;

	modport source (output valid, output digest_word, output word_index, output last_word,
		output too_long, input ready);
	modport sink (input valid, input digest_word, input word_index, input last_word,
		input too_long, output ready);
endinterface

>>> design/sha0_hash_engine.sv
// SHA-0 hash engine.
// message channel (sink): operation 0 appends data_byte, operation 1 finishes
// the message. digest channel (source): five 32-bit words per finish, index
// 0 first, last_word on index 4, too_long set when the bit length overflowed.
// The byte that completes a 64-byte block starts a compression: 80 rounds
// on the one shared round unit, one round a cycle, then a fold into the
// chaining value, before message is ready again.
// A finish shifts in padding and length one byte a cycle through the block
// shift line (up to 63 bytes, or up to 7 zeros plus a full second block of
// 64 when the length spills over), compresses once or twice, then presents
// the digest words, one per cycle while digest.ready is high.
// While the receiver stalls the current word holds and no input is taken;
// after the fifth word transfers the engine is back at the initial state.
// Reset sets the initial chaining value and clears length and fill count;
// block contents need no reset.
module sha0_hash_engine (
	input  logic            clk,
	input  logic            arst_n,
	sha0_in_if.sink         message,
	sha0_out_if.source      digest
);

	sha0_pkg::state_t      state_q;
	sha0_pkg::chain_t      chain_q;
	sha0_pkg::chain_t      work;
	sha0_pkg::round_ctrl_t rctrl;
	sha0_pkg::word_t       w_cur;
	sha0_pkg::byte_t       byte_in;
	sha0_pkg::byte_t       len_byte;
	logic [6:0]            fill_q;
	logic [63:0]           bitlen_q;
	logic [63:0]           bitlen_next;
	logic                  ovf_q;
	logic                  fin_q;
	logic                  lenph_q;
	logic [4:0]            sub_q;
	logic [1:0]            phase_q;
	logic [2:0]            idx_q;
	logic                  in_xfer;
	logic                  out_xfer;
	logic                  shift_byte;
	logic                  pad_full;
	logic                  round_last;

	assign message.ready = (state_q == sha0_pkg::ST_IDLE);
	assign in_xfer  = message.valid && message.ready;
	assign out_xfer = digest.valid && digest.ready;

	assign bitlen_next = bitlen_q + 64'd8;
	assign pad_full    = (fill_q == 7'(sha0_pkg::BLOCK_BYTES));
	assign round_last  = (phase_q == 2'(sha0_pkg::PH_PARITY2))
		&& (sub_q == 5'(sha0_pkg::PHASE_LEN - 1));
	assign len_byte    = bitlen_q[{~fill_q[2:0], 3'b000} +: 8];

	// byte source for the block shift line
	always_comb begin
		shift_byte = 1'b0;
		byte_in    = message.data_byte;
		if (state_q == sha0_pkg::ST_IDLE && in_xfer) begin
			if (message.operation) begin
				shift_byte = 1'b1;
				byte_in    = sha0_pkg::PAD_BYTE;
			end else begin
				shift_byte = !ovf_q;
			end
		end else if (state_q == sha0_pkg::ST_PAD && !pad_full) begin
			shift_byte = 1'b1;
			if (lenph_q || fill_q == 7'(sha0_pkg::LEN_POS)) begin
				byte_in = len_byte;
			end else begin
				byte_in = 8'h00;
			end
		end
	end

	// round unit control
	always_comb begin
		rctrl.load  = (state_q == sha0_pkg::ST_IDLE && in_xfer && !message.operation && !ovf_q
			&& fill_q == 7'(sha0_pkg::BLOCK_BYTES - 1))
			|| (state_q == sha0_pkg::ST_PAD && pad_full);
		rctrl.step  = (state_q == sha0_pkg::ST_ROUND);
		rctrl.phase = sha0_pkg::phase_t'(phase_q);
	end

	sha0_sched u_sched (
		.clk        (clk),
		.shift_byte (shift_byte),
		.byte_in    (byte_in),
		.shift_word (state_q == sha0_pkg::ST_ROUND),
		.w_cur      (w_cur)
	);

	sha0_round u_round (
		.clk   (clk),
		.ctrl  (rctrl),
		.chain (chain_q),
		.w_cur (w_cur),
		.work  (work)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sha0_pkg::ST_IDLE;
			chain_q  <= sha0_pkg::INIT_H;
			fill_q   <= '0;
			bitlen_q <= '0;
			ovf_q    <= 1'b0;
			fin_q    <= 1'b0;
			lenph_q  <= 1'b0;
			sub_q    <= '0;
			phase_q  <= '0;
			idx_q    <= '0;
		end else begin
			case (state_q)
				sha0_pkg::ST_IDLE: begin
					if (in_xfer) begin
						if (message.operation) begin
							fin_q   <= 1'b1;
							lenph_q <= 1'b0;
							fill_q  <= fill_q + 7'd1;
							state_q <= sha0_pkg::ST_PAD;
						end else if (!ovf_q) begin
							bitlen_q <= bitlen_next;
							if (bitlen_next == 64'd0) begin
								ovf_q <= 1'b1;
							end
							if (rctrl.load) begin
								fill_q  <= '0;
								sub_q   <= '0;
								phase_q <= '0;
								state_q <= sha0_pkg::ST_ROUND;
							end else begin
								fill_q <= fill_q + 7'd1;
							end
						end
					end
				end
				sha0_pkg::ST_PAD: begin
					if (pad_full) begin
						fill_q  <= '0;
						sub_q   <= '0;
						phase_q <= '0;
						state_q <= sha0_pkg::ST_ROUND;
					end else begin
						if (fill_q == 7'(sha0_pkg::LEN_POS)) begin
							lenph_q <= 1'b1;
						end
						fill_q <= fill_q + 7'd1;
					end
				end
				sha0_pkg::ST_ROUND: begin
					if (round_last) begin
						state_q <= sha0_pkg::ST_FOLD;
					end else if (sub_q == 5'(sha0_pkg::PHASE_LEN - 1)) begin
						sub_q   <= '0;
						phase_q <= phase_q + 2'd1;
					end else begin
						sub_q <= sub_q + 5'd1;
					end
				end
				sha0_pkg::ST_FOLD: begin
					for (int i = 0; i < sha0_pkg::WORD_COUNT; i++) begin
						chain_q[i] <= chain_q[i] + work[i];
					end
					if (!fin_q) begin
						state_q <= sha0_pkg::ST_IDLE;
					end else if (lenph_q) begin
						idx_q   <= '0;
						state_q <= sha0_pkg::ST_EMIT;
					end else begin
						state_q <= sha0_pkg::ST_PAD;
					end
				end
				sha0_pkg::ST_EMIT: begin
					if (out_xfer) begin
						if (idx_q == 3'(sha0_pkg::WORD_COUNT - 1)) begin
							chain_q  <= sha0_pkg::INIT_H;
							fill_q   <= '0;
							bitlen_q <= '0;
							ovf_q    <= 1'b0;
							fin_q    <= 1'b0;
							lenph_q  <= 1'b0;
							state_q  <= sha0_pkg::ST_IDLE;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= sha0_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// digest words straight from the chaining registers
	assign digest.valid       = (state_q == sha0_pkg::ST_EMIT);
	assign digest.digest_word = chain_q[idx_q];
	assign digest.word_index  = idx_q;
	assign digest.last_word   = (idx_q == 3'(sha0_pkg::WORD_COUNT - 1));
	assign digest.too_long    = ovf_q;

	// no input transfer while a digest word is offered
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(message.ready && digest.valid))
		else $error("input ready while digest word offered");

	// fill count never passes a full block
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= 7'(sha0_pkg::BLOCK_BYTES))
		else $error("block fill out of range");

	// last digest transfer leaves a clean message state
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && digest.last_word) |=>
		(state_q == sha0_pkg::ST_IDLE && fill_q == 7'd0 && !ovf_q && bitlen_q == 64'd0))
		else $error("message state not cleared after digest");

	// rounds start from a block with the fill count cleared
	a_round_entry: assert property (@(posedge clk) disable iff (!arst_n)
		rctrl.load |=> (state_q == sha0_pkg::ST_ROUND && sub_q == 5'd0 && fill_q == 7'd0))
		else $error("compression started in wrong state");

endmodule

>>> design/sha0_sched.sv
module sha0_sched (
	input  logic              clk,
	input  logic              shift_byte,
	input  sha0_pkg::byte_t   byte_in,
	input  logic              shift_word,
	output sha0_pkg::word_t   w_cur
);

	sha0_pkg::byte_t blk_q [sha0_pkg::BLOCK_BYTES];
	sha0_pkg::word_t w_new;

	// next schedule word from the sliding window
	always_comb begin
		w_new = {blk_q[52], blk_q[53], blk_q[54], blk_q[55]}
			^ {blk_q[32], blk_q[33], blk_q[34], blk_q[35]}
			^ {blk_q[8], blk_q[9], blk_q[10], blk_q[11]}
			^ {blk_q[0], blk_q[1], blk_q[2], blk_q[3]};
	end

	assign w_cur = {blk_q[0], blk_q[1], blk_q[2], blk_q[3]};

	// byte shift line: bytes enter at the tail, rounds shift a word at a time
	always_ff @(posedge clk) begin
		if (shift_byte) begin
			for (int i = 0; i < sha0_pkg::BLOCK_BYTES - 1; i++) begin
				blk_q[i] <= blk_q[i+1];
			end
			blk_q[sha0_pkg::BLOCK_BYTES-1] <= byte_in;
		end else if (shift_word) begin
			for (int i = 0; i < sha0_pkg::BLOCK_BYTES - 4; i++) begin
				blk_q[i] <= blk_q[i+4];
			end
			blk_q[sha0_pkg::BLOCK_BYTES-4] <= w_new[31:24];
			blk_q[sha0_pkg::BLOCK_BYTES-3] <= w_new[23:16];
			blk_q[sha0_pkg::BLOCK_BYTES-2] <= w_new[15:8];
			blk_q[sha0_pkg::BLOCK_BYTES-1] <= w_new[7:0];
		end
	end

endmodule

>>> design/sha0_round.sv
module sha0_round (
	input  logic                  clk,
	input  sha0_pkg::round_ctrl_t ctrl,
	input  sha0_pkg::chain_t      chain,
	input  sha0_pkg::word_t       w_cur,
	output sha0_pkg::chain_t      work
);

	sha0_pkg::word_t a_q, b_q, c_q, d_q, e_q;
	sha0_pkg::word_t f;
	sha0_pkg::word_t k;
	sha0_pkg::word_t t;

	// round function and constant
	always_comb begin
		case (ctrl.phase)
			sha0_pkg::PH_CHOOSE: f = (b_q & c_q) | (~b_q & d_q);
			sha0_pkg::PH_MAJOR:  f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			default:             f = b_q ^ c_q ^ d_q;
		endcase
		k = sha0_pkg::ROUND_K[ctrl.phase];
		t = {a_q[26:0], a_q[31:27]} + f + e_q + w_cur + k;
	end

	// working variables
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			a_q <= chain[0];
			b_q <= chain[1];
			c_q <= chain[2];
			d_q <= chain[3];
			e_q <= chain[4];
		end else if (ctrl.step) begin
			a_q <= t;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	assign work = '{e_q, d_q, c_q, b_q, a_q};

endmodule

>>> tb/sha0_hash_engine_tb.sv
module sha0_hash_engine_tb;

	localparam int CLK_HALF    = 4;
	localparam int RESET_CYCLES = 2;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 300;
	localparam int RANDOM_ITEMS = 120;
	localparam int MIN_FINISHES = 12;
	localparam int MAX_REPORTS = 10;

	typedef enum logic {
		OP_APPEND = 1'b0,
		OP_FINISH = 1'b1
	} op_t;

	typedef enum int {
		RDY_ALWAYS = 0,
		RDY_RANDOM = 1,
		RDY_THIRD  = 2
	} ready_mode_t;

	// one message item; hold makes the sender wait for an empty scoreboard
	typedef struct packed {
		op_t             op;
		sha0_pkg::byte_t data;
		logic            hold;
	} msg_item_t;

	typedef struct packed {
		sha0_pkg::word_t word;
		logic [2:0]      index;
		logic            last;
		logic            too_long;
	} digest_word_t;

	localparam sha0_pkg::word_t IV0 = 32'h67452301;
	localparam sha0_pkg::word_t IV1 = 32'hEFCDAB89;
	localparam sha0_pkg::word_t IV2 = 32'h98BADCFE;
	localparam sha0_pkg::word_t IV3 = 32'h10325476;
	localparam sha0_pkg::word_t IV4 = 32'hC3D2E1F0;
	localparam sha0_pkg::word_t K_CH  = 32'h5A827999;
	localparam sha0_pkg::word_t K_PA1 = 32'h6ED9EBA1;
	localparam sha0_pkg::word_t K_MAJ = 32'h8F1BBCDC;
	localparam sha0_pkg::word_t K_PA2 = 32'hCA62C1D6;
	localparam sha0_pkg::byte_t PAD_MARK = 8'h80;

	logic clk = 1'b0;
	logic arst_n;

	sha0_in_if  message_ch();
	sha0_out_if digest_ch();

	sha0_hash_engine u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.message(message_ch),
		.digest (digest_ch)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	msg_item_t    message_q[$];
	digest_word_t digest_q[$];
	int           fail_count = 0;
	bit           hold_next = 1'b0;

	// hash state as the engine should hold it
	sha0_pkg::word_t hash_chain[5];
	sha0_pkg::byte_t msg_block[64];
	int unsigned     msg_fill;
	logic [63:0]     msg_bits;
	logic            msg_overflow;

	function automatic void sha0_restart();
		hash_chain[0] = IV0;
		hash_chain[1] = IV1;
		hash_chain[2] = IV2;
		hash_chain[3] = IV3;
		hash_chain[4] = IV4;
		msg_fill = 0;
		msg_bits = '0;
		msg_overflow = 1'b0;
	endfunction

	// 80 rounds over the current block, no rotate in the schedule
	function automatic void sha0_compress();
		sha0_pkg::word_t w[80];
		sha0_pkg::word_t a, b, c, d, e, f, k, t;
		for (int i = 0; i < 16; i++)
			w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
		for (int i = 16; i < 80; i++)
			w[i] = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
		a = hash_chain[0];
		b = hash_chain[1];
		c = hash_chain[2];
		d = hash_chain[3];
		e = hash_chain[4];
		for (int i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d);
				k = K_CH;
			end else if (i < 40) begin
				f = b ^ c ^ d;
				k = K_PA1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = K_MAJ;
			end else begin
				f = b ^ c ^ d;
				k = K_PA2;
			end
			t = {a[26:0], a[31:27]} + f + e + w[i] + k;
			e = d;
			d = c;
			c = {b[1:0], b[31:2]};
			b = a;
			a = t;
		end
		hash_chain[0] += a;
		hash_chain[1] += b;
		hash_chain[2] += c;
		hash_chain[3] += d;
		hash_chain[4] += e;
		msg_fill = 0;
	endfunction

	// absorb one transferred item, queue the digest words a finish yields
	function automatic void sha0_absorb(msg_item_t item);
		int pos;
		digest_word_t dw;
		if (item.op == OP_APPEND) begin
			if (msg_overflow)
				return;
			msg_block[msg_fill % 64] = item.data;
			msg_fill = (msg_fill % 64) + 1;
			msg_bits += 64'd8;
			if (msg_bits == 64'd0)
				msg_overflow = 1'b1;
			if (msg_fill >= 64)
				sha0_compress();
			return;
		end
		pos = msg_fill % 64;
		msg_block[pos] = PAD_MARK;
		pos++;
		// length spills into a second block
		if (pos > 56) begin
			while (pos < 64) begin
				msg_block[pos] = 8'h00;
				pos++;
			end
			sha0_compress();
			pos = 0;
		end
		while (pos < 56) begin
			msg_block[pos] = 8'h00;
			pos++;
		end
		for (int i = 0; i < 8; i++)
			msg_block[56+i] = msg_bits[63-8*i -: 8];
		sha0_compress();
		for (int i = 0; i < 5; i++) begin
			dw.word = hash_chain[i];
			dw.index = 3'(i);
			dw.last = (i == 4);
			dw.too_long = msg_overflow;
			digest_q.push_back(dw);
		end
		sha0_restart();
	endfunction

	function automatic void add_item(op_t op, sha0_pkg::byte_t data);
		msg_item_t item;
		item.op = op;
		item.data = data;
		item.hold = hold_next;
		hold_next = 1'b0;
		message_q.push_back(item);
	endfunction

	// sender: bursts of transfers separated by random gaps
	msg_item_t cur_item;
	int        burst_left;
	int        gap_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			message_ch.valid <= 1'b0;
			message_ch.operation <= OP_APPEND;
			message_ch.data_byte <= 8'h00;
			burst_left = 1;
			gap_left = 0;
		end else begin
			if (message_ch.valid && message_ch.ready)
				sha0_absorb(cur_item);
			if (!message_ch.valid || message_ch.ready) begin
				if (gap_left != 0) begin
					gap_left--;
					message_ch.valid <= 1'b0;
				end else if (message_q.size() == 0 ||
						(message_q[0].hold && digest_q.size() != 0)) begin
					message_ch.valid <= 1'b0;
				end else begin
					cur_item = message_q.pop_front();
					message_ch.valid <= 1'b1;
					message_ch.operation <= cur_item.op;
					message_ch.data_byte <= cur_item.data;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left--;
					end
				end
			end
		end
	end

	// receiver: checks each digest transfer, stalls on a changing pattern
	digest_word_t want;
	ready_mode_t  ready_mode;
	int           mode_left;
	int unsigned  ready_tick;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digest_ch.ready <= 1'b0;
			ready_mode = RDY_ALWAYS;
			mode_left = 0;
			ready_tick = 0;
		end else begin
			if (digest_ch.valid && digest_ch.ready) begin
				if (digest_q.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("unexpected digest word %h index %0d",
							digest_ch.digest_word, digest_ch.word_index);
				end else begin
					want = digest_q.pop_front();
					if (digest_ch.digest_word !== want.word || digest_ch.word_index !== want.index ||
							digest_ch.last_word !== want.last ||
							digest_ch.too_long !== want.too_long) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS)
							$display("digest mismatch: exp %h/%0d/%b/%b got %h/%0d/%b/%b",
								want.word, want.index, want.last, want.too_long,
								digest_ch.digest_word, digest_ch.word_index,
								digest_ch.last_word, digest_ch.too_long);
					end
				end
			end
			if (mode_left == 0) begin
				ready_mode = ready_mode_t'($urandom_range(0, 2));
				mode_left = $urandom_range(8, 64);
			end else begin
				mode_left--;
			end
			ready_tick++;
			case (ready_mode)
				RDY_ALWAYS: begin
					digest_ch.ready <= 1'b1;
				end
				RDY_RANDOM: begin
					digest_ch.ready <= 1'($urandom_range(0, 1));
				end
				default: begin
					digest_ch.ready <= (ready_tick % 3 == 0);
				end
			endcase
		end
	end

	// run limit
	int unsigned cycle_count = 0;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("sha0_hash_engine_tb NOT OK");
			$finish;
		end
	end

	int edge_lens[6] = '{55, 56, 57, 63, 64, 65};
	int rand_items;
	int rand_finishes;
	int msg_len;

	initial begin
		message_ch.valid = 1'b0;
		message_ch.operation = OP_APPEND;
		message_ch.data_byte = 8'h00;
		digest_ch.ready = 1'b0;
		arst_n = 1'b0;
		sha0_restart();

		// directed: empty message, "abc", single extreme bytes, back-to-back finishes
		add_item(OP_FINISH, 8'h00);
		add_item(OP_APPEND, 8'h61);
		add_item(OP_APPEND, 8'h62);
		add_item(OP_APPEND, 8'h63);
		add_item(OP_FINISH, 8'hFF);
		add_item(OP_FINISH, 8'h00);
		add_item(OP_APPEND, 8'h00);
		add_item(OP_FINISH, 8'h00);
		add_item(OP_APPEND, 8'hFF);
		add_item(OP_FINISH, 8'hFF);
		add_item(OP_APPEND, 8'h55);
		add_item(OP_APPEND, 8'hAA);
		add_item(OP_FINISH, 8'h5A);

		// random messages, mostly short, some around the padding boundaries
		rand_items = 0;
		rand_finishes = 0;
		hold_next = 1'b1;
		while (rand_items < RANDOM_ITEMS || rand_finishes < MIN_FINISHES) begin
			if (rand_finishes == MIN_FINISHES / 2)
				hold_next = 1'b1;
			if ($urandom_range(0, 7) == 0)
				msg_len = edge_lens[$urandom_range(0, 5)];
			else
				msg_len = $urandom_range(0, 12);
			for (int j = 0; j < msg_len; j++)
				add_item(OP_APPEND, sha0_pkg::byte_t'($urandom_range(0, 255)));
			add_item(OP_FINISH, sha0_pkg::byte_t'($urandom_range(0, 255)));
			rand_items += msg_len + 1;
			rand_finishes++;
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		while (message_q.size() != 0 || message_ch.valid)
			@(posedge clk);
		while (digest_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (fail_count == 0 && digest_q.size() == 0)
			$display("sha0_hash_engine_tb OK");
		else
			$display("sha0_hash_engine_tb NOT OK");
		$finish;
	end

endmodule
